// File: hdl/rfc_pkg.sv
package rfc_pkg;

  localparam int LEVEL_W = 8;
  localparam int ACC_W   = 17;
  localparam int SPEED_W = 8;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd255;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd10;

  // ASCII codes; OR-ing CASE_BIT into a letter gives its lower case form
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CHR_R    = 8'h72;
  localparam logic [7:0] CHR_G    = 8'h67;
  localparam logic [7:0] CHR_B    = 8'h62;
  localparam logic [7:0] CHR_F    = 8'h66;
  localparam logic [7:0] CHR_A    = 8'h61;
  localparam logic [7:0] CHR_D    = 8'h64;
  localparam logic [7:0] CHR_X    = 8'h78;
  localparam logic [7:0] CHR_0    = 8'h30;
  localparam logic [7:0] CHR_9    = 8'h39;

  typedef enum logic [1:0] {
    CMD_RED   = 2'd0,
    CMD_GREEN = 2'd1,
    CMD_BLUE  = 2'd2,
    CMD_FADE  = 2'd3
  } cmd_sel_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CANCEL  = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_STEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic               en;
    cmd_sel_t           sel;
    logic [LEVEL_W-1:0] value;
  } cmd_wr_t;

  typedef struct packed {
    cmd_wr_t wr;
    status_t status;
  } parse_res_t;

endpackage

// File: hdl/rfc_divider.sv
module rfc_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rfc_pkg::ACC_W-1:0]   dividend,
  input  logic [rfc_pkg::SPEED_W-1:0] divisor,
  output logic                        done,
  output logic [rfc_pkg::ACC_W-1:0]   quotient,
  output logic [rfc_pkg::SPEED_W-1:0] remainder
);

  logic                          running;
  logic [rfc_pkg::DIV_CNT_W-1:0] cnt;
  logic [rfc_pkg::ACC_W-1:0]     quo;
  logic [rfc_pkg::SPEED_W-1:0]   rem;
  logic [rfc_pkg::SPEED_W-1:0]   dvs;

  logic [rfc_pkg::SPEED_W:0]     shifted;
  logic [rfc_pkg::SPEED_W:0]     diff;
  logic                          ge;
  logic [rfc_pkg::SPEED_W-1:0]   rem_next;
  logic [rfc_pkg::ACC_W-1:0]     quo_next;

  // one restoring step: bring down the next dividend bit, trial subtract
  always_comb begin
    shifted  = {rem, quo[rfc_pkg::ACC_W-1]};
    diff     = shifted - {1'b0, dvs};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? diff[rfc_pkg::SPEED_W-1:0] : shifted[rfc_pkg::SPEED_W-1:0];
    quo_next = {quo[rfc_pkg::ACC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= rfc_pkg::DIV_CNT_W'(rfc_pkg::ACC_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == rfc_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  a_no_step_when_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !running)
    else $error("divider still running at done");

  a_done_after_last_step: assert property (@(posedge clk) disable iff (rst)
    (running && !start && cnt == rfc_pkg::DIV_CNT_W'(1)) |=> done)
    else $error("divider missed its done pulse");

endmodule

// File: hdl/rfc_parser.sv
module rfc_parser #(
  parameter int DIGITS_PER_COMMAND = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_code,
  output rfc_pkg::parse_res_t res
);

  localparam logic [1:0] DIGITS_LAST = 2'(DIGITS_PER_COMMAND);

  logic                          pending;
  logic                          pending_next;
  logic [1:0]                    count;
  logic [1:0]                    count_next;
  logic [rfc_pkg::LEVEL_W-1:0]   number;
  logic [rfc_pkg::LEVEL_W-1:0]   number_next;
  rfc_pkg::cmd_sel_t             target;
  rfc_pkg::cmd_sel_t             target_next;

  logic [7:0]                    lc;
  logic                          is_digit;
  logic [rfc_pkg::LEVEL_W-1:0]   digit_val;
  logic [rfc_pkg::LEVEL_W-1:0]   number_acc;
  logic [1:0]                    count_inc;

  always_comb begin
    lc         = char_code | rfc_pkg::CASE_BIT;
    is_digit   = (char_code >= rfc_pkg::CHR_0) && (char_code <= rfc_pkg::CHR_9);
    digit_val  = char_code - rfc_pkg::CHR_0;
    // times ten as two shifts, wrapping at eight bits
    number_acc = {number[4:0], 3'b000} + {number[6:0], 1'b0} + digit_val;
    count_inc  = count + 2'd1;
  end

  always_comb begin
    pending_next = pending;
    count_next   = count;
    number_next  = number;
    target_next  = target;
    res.wr.en    = 1'b0;
    res.wr.sel   = target;
    res.wr.value = number_acc;
    res.status   = rfc_pkg::ST_OK;
    priority if (lc == rfc_pkg::CHR_R || lc == rfc_pkg::CHR_G ||
                 lc == rfc_pkg::CHR_B || lc == rfc_pkg::CHR_F) begin
      pending_next = 1'b1;
      count_next   = '0;
      number_next  = '0;
      unique case (lc)
        rfc_pkg::CHR_R: target_next = rfc_pkg::CMD_RED;
        rfc_pkg::CHR_G: target_next = rfc_pkg::CMD_GREEN;
        rfc_pkg::CHR_B: target_next = rfc_pkg::CMD_BLUE;
        default:        target_next = rfc_pkg::CMD_FADE;
      endcase
    end else if (lc == rfc_pkg::CHR_A || lc == rfc_pkg::CHR_D ||
                 lc == rfc_pkg::CHR_X) begin
      // ignored letters leave everything alone
    end else if (!pending) begin
      res.status = rfc_pkg::ST_UNKNOWN;
    end else if (!is_digit) begin
      pending_next = 1'b0;
      res.status   = rfc_pkg::ST_CANCEL;
    end else begin
      number_next = number_acc;
      count_next  = count_inc;
      if (count_inc >= DIGITS_LAST) begin
        pending_next = 1'b0;
        res.wr.en    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
      number  <= '0;
      target  <= rfc_pkg::CMD_RED;
    end else if (accept) begin
      pending <= pending_next;
      count   <= count_next;
      number  <= number_next;
      target  <= target_next;
    end
  end

endmodule

// File: hdl/rgb_fade_command_controller.sv
// LED level fader with a serial command parser.
// Input channel (in_valid / in_stall): kind 0 carries elapsed_ms, kind 1
// carries one command character in char_code. Every accepted item yields
// exactly one result on the output channel (out_valid / out_stall): the
// three shown levels, the settled flag and a parse status.
// A time item runs the 17-step shift/subtract divider that turns the
// millisecond accumulator into a step size, then walks the channels one per
// cycle through a single compare/adder, and the finish state loads the result
// register. With a fade speed of zero the divider is skipped. A character item
// is parsed in the accept cycle and goes straight to the finish state. The next
// item can be taken in the cycle after the result register is loaded.
// The result register holds while out_stall is high; a new item can still
// be accepted then, and its result waits until the register is free.
// Reset (rst, synchronous) sets all levels and targets to 255, fade speed
// to 10, clears the accumulator and any pending command, and sets the settled flag.
module rgb_fade_command_controller #(
  parameter int CHANNELS           = 3,
  parameter int DIGITS_PER_COMMAND = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [15:0] elapsed_ms,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_level,
  output logic [7:0] green_level,
  output logic [7:0] blue_level,
  output logic       settled,
  output logic [1:0] status
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  rfc_pkg::state_t              state;
  rfc_pkg::state_t              state_next;

  logic [rfc_pkg::LEVEL_W-1:0]  actual [CHANNELS];
  logic [rfc_pkg::LEVEL_W-1:0]  target [CHANNELS];
  logic [rfc_pkg::ACC_W-1:0]    acc;
  logic [rfc_pkg::ACC_W-1:0]    acc_sum;
  logic [rfc_pkg::ACC_W-1:0]    step;
  logic [rfc_pkg::SPEED_W-1:0]  fade_speed;
  logic                         settled_flag;
  logic [CH_W-1:0]              ch;
  rfc_pkg::status_t             item_status;

  logic [rfc_pkg::LEVEL_W-1:0]  out_lvl [3];
  logic [rfc_pkg::LEVEL_W-1:0]  view_lvl [3];
  logic                         out_settled;
  rfc_pkg::status_t             out_status;

  logic                         in_accept;
  logic                         time_accept;
  logic                         char_accept;
  logic                         speed_zero;
  logic                         div_start;
  logic                         div_done;
  logic [rfc_pkg::ACC_W-1:0]    div_quo;
  logic [rfc_pkg::SPEED_W-1:0]  div_rem;
  logic                         step_en;
  logic                         load_out;
  rfc_pkg::parse_res_t          parse;

  logic [rfc_pkg::LEVEL_W-1:0]  cur_a;
  logic [rfc_pkg::LEVEL_W-1:0]  cur_t;
  logic                         up;
  logic [rfc_pkg::LEVEL_W-1:0]  gap;
  logic                         reach;
  logic [rfc_pkg::LEVEL_W-1:0]  moved;

  assign in_accept   = in_valid && !in_stall;
  assign time_accept = in_accept && !kind;
  assign char_accept = in_accept && kind;
  assign speed_zero  = (fade_speed == '0);
  assign acc_sum     = acc + rfc_pkg::ACC_W'(elapsed_ms);

  rfc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc_sum),
    .divisor   (fade_speed),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rfc_parser #(
    .DIGITS_PER_COMMAND (DIGITS_PER_COMMAND)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (char_accept),
    .char_code (char_code),
    .res       (parse)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rfc_pkg::S_IDLE: begin
        if (char_accept) begin
          state_next = rfc_pkg::S_FINISH;
        end else if (time_accept) begin
          state_next = speed_zero ? rfc_pkg::S_STEP : rfc_pkg::S_DIVIDE;
        end
      end
      rfc_pkg::S_DIVIDE: begin
        if (div_done) begin
          state_next = rfc_pkg::S_STEP;
        end
      end
      rfc_pkg::S_STEP: begin
        if (ch == CH_LAST) begin
          state_next = rfc_pkg::S_FINISH;
        end
      end
      rfc_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = rfc_pkg::S_IDLE;
        end
      end
      default: state_next = rfc_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    step_en   = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      rfc_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        div_start = time_accept && !speed_zero;
      end
      rfc_pkg::S_DIVIDE: begin
      end
      rfc_pkg::S_STEP: begin
        step_en = 1'b1;
      end
      rfc_pkg::S_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  // shared compare/adder for the channel walk
  always_comb begin
    cur_a = actual[ch];
    cur_t = target[ch];
    up    = cur_t > cur_a;
    gap   = up ? (cur_t - cur_a) : (cur_a - cur_t);
    reach = rfc_pkg::ACC_W'(gap) < step;
    // without reach, step <= gap fits in eight bits
    moved = reach ? cur_t :
            (up ? cur_a + step[rfc_pkg::LEVEL_W-1:0]
                : cur_a - step[rfc_pkg::LEVEL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rfc_pkg::S_IDLE;
      acc          <= '0;
      fade_speed   <= rfc_pkg::SPEED_RESET;
      settled_flag <= 1'b1;
      ch           <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        actual[i] <= rfc_pkg::LEVEL_RESET;
        target[i] <= rfc_pkg::LEVEL_RESET;
      end
    end else begin
      state <= state_next;

      if (time_accept) begin
        ch           <= '0;
        settled_flag <= 1'b1;
        if (speed_zero) begin
          acc <= '0;
        end else begin
          acc <= acc_sum;
        end
      end

      if (state == rfc_pkg::S_DIVIDE && div_done) begin
        acc <= rfc_pkg::ACC_W'(div_rem);
      end

      if (step_en) begin
        if (cur_a != cur_t) begin
          actual[ch]   <= moved;
          settled_flag <= 1'b0;
        end
        ch <= ch + 1'b1;
      end

      if (char_accept && parse.wr.en) begin
        settled_flag <= 1'b0;
        if (parse.wr.sel == rfc_pkg::CMD_FADE) begin
          fade_speed <= parse.wr.value;
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (parse.wr.sel != rfc_pkg::CMD_FADE && int'(parse.wr.sel) == i) begin
            target[i] <= parse.wr.value;
          end
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (time_accept) begin
      item_status <= rfc_pkg::ST_OK;
      step        <= speed_zero ? '1 : step;
    end else if (char_accept) begin
      item_status <= parse.status;
    end
    if (state == rfc_pkg::S_DIVIDE && div_done) begin
      step <= div_quo;
    end
    if (load_out) begin
      out_lvl     <= view_lvl;
      out_settled <= settled_flag;
      out_status  <= item_status;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_view
    if (j < CHANNELS) begin : g_present
      assign view_lvl[j] = actual[j];
    end else begin : g_absent
      assign view_lvl[j] = '0;
    end
  end

  assign red_level   = out_lvl[0];
  assign green_level = out_lvl[1];
  assign blue_level  = out_lvl[2];
  assign settled     = out_settled;
  assign status      = out_status;

  a_divide_needs_speed: assert property (@(posedge clk) disable iff (rst)
    (state == rfc_pkg::S_DIVIDE) |-> !speed_zero)
    else $error("divider running with zero fade speed");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == rfc_pkg::S_STEP) |-> (ch <= CH_LAST))
    else $error("channel index out of range");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && state == rfc_pkg::S_IDLE))
    else $error("result not presented after finish");

  a_acc_below_speed: assert property (@(posedge clk) disable iff (rst)
    (state == rfc_pkg::S_STEP) |-> (speed_zero || acc < rfc_pkg::ACC_W'(fade_speed)))
    else $error("accumulator remainder not reduced");

endmodule

// File: bench/tb_rgb_fade_command_controller.sv
`timescale 1ns / 1ps

module tb_rgb_fade_command_controller;

  localparam int CHANNELS       = 3;
  localparam int DIGITS         = 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 30;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             settled;
    rfc_pkg::status_t status;
  } led_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [15:0] elapsed_ms;
  logic [7:0]  char_code;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;
  logic        settled;
  logic [1:0]  status;

  rgb_fade_command_controller #(
    .CHANNELS          (CHANNELS),
    .DIGITS_PER_COMMAND(DIGITS)
  ) dut (.*);

  // fader state as the testbench sees it
  logic [7:0]                lvl_now [CHANNELS];
  logic [7:0]                lvl_goal [CHANNELS];
  logic [rfc_pkg::ACC_W-1:0] ms_acc;
  logic [7:0]                speed;
  logic                      all_settled;
  logic                      cmd_pending;
  logic [1:0]                digits_seen;
  logic [7:0]                cmd_value;
  rfc_pkg::cmd_sel_t         cmd_sel;

  led_result_t expected_levels[$];
  int          mismatches = 0;
  bit          gaps_on = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  bit          hold_req = 0;
  int          hold_left = 0;
  int          stall_phase = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic fader_reset();
    int i;
    for (i = 0; i < CHANNELS; i++) begin
      lvl_now[i]  = rfc_pkg::LEVEL_RESET;
      lvl_goal[i] = rfc_pkg::LEVEL_RESET;
    end
    ms_acc      = '0;
    speed       = rfc_pkg::SPEED_RESET;
    all_settled = 1'b1;
    cmd_pending = 1'b0;
    digits_seen = '0;
    cmd_value   = '0;
    cmd_sel     = rfc_pkg::CMD_RED;
  endtask

  function automatic led_result_t fade_predict(input logic k, input logic [15:0] ms,
                                               input logic [7:0] ch);
    led_result_t res;
    int unsigned step;
    int unsigned a;
    int unsigned t;
    logic [7:0]  lc;
    int          i;
    res.status = rfc_pkg::ST_OK;
    if (!k) begin
      ms_acc = ms_acc + rfc_pkg::ACC_W'(ms);
      if (speed == 0) begin
        // no divide: every channel lands on its target
        step   = 32'h1FFFF;
        ms_acc = '0;
      end else begin
        step   = 32'(ms_acc / speed);
        ms_acc = ms_acc % speed;
      end
      all_settled = 1'b1;
      for (i = 0; i < CHANNELS; i++) begin
        a = lvl_now[i];
        t = lvl_goal[i];
        if (t > a) begin
          all_settled = 1'b0;
          lvl_now[i]  = 8'((t - a < step) ? t : a + step);
        end else if (t < a) begin
          all_settled = 1'b0;
          lvl_now[i]  = 8'((a - t < step) ? t : a - step);
        end
      end
    end else begin
      lc = ch | rfc_pkg::CASE_BIT;
      if (lc == rfc_pkg::CHR_R || lc == rfc_pkg::CHR_G || lc == rfc_pkg::CHR_B ||
          lc == rfc_pkg::CHR_F) begin
        cmd_pending = 1'b1;
        digits_seen = '0;
        cmd_value   = '0;
        cmd_sel     = (lc == rfc_pkg::CHR_R) ? rfc_pkg::CMD_RED :
                      (lc == rfc_pkg::CHR_G) ? rfc_pkg::CMD_GREEN :
                      (lc == rfc_pkg::CHR_B) ? rfc_pkg::CMD_BLUE : rfc_pkg::CMD_FADE;
      end else if (lc == rfc_pkg::CHR_A || lc == rfc_pkg::CHR_D || lc == rfc_pkg::CHR_X) begin
        // ignored letters leave a pending command alone
      end else if (!cmd_pending) begin
        res.status = rfc_pkg::ST_UNKNOWN;
      end else if (ch < rfc_pkg::CHR_0 || ch > rfc_pkg::CHR_9) begin
        cmd_pending = 1'b0;
        res.status  = rfc_pkg::ST_CANCEL;
      end else begin
        cmd_value   = cmd_value * 8'd10 + (ch - rfc_pkg::CHR_0);
        digits_seen = digits_seen + 2'd1;
        if (int'(digits_seen) >= DIGITS) begin
          cmd_pending = 1'b0;
          all_settled = 1'b0;
          if (cmd_sel == rfc_pkg::CMD_FADE) speed = cmd_value;
          else lvl_goal[cmd_sel] = cmd_value;
        end
      end
    end
    res.red     = lvl_now[0];
    res.green   = lvl_now[1];
    res.blue    = lvl_now[2];
    res.settled = all_settled;
    return res;
  endfunction

  task automatic send_item(input logic k, input logic [15:0] ms, input logic [7:0] ch);
    int idle;
    idle = 0;
    if (gaps_on && burst_left <= 0) begin
      idle       = $urandom_range(1, 30);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    elapsed_ms <= ms;
    char_code  <= ch;
    do @(posedge clk); while (in_stall);
    expected_levels.push_back(fade_predict(k, ms, ch));
  endtask

  // the unused field carries noise so its bits toggle too
  task automatic send_time(input logic [15:0] ms);
    send_item(1'b0, ms, 8'($urandom));
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(1'b1, 16'($urandom), ch);
  endtask

  function automatic logic [7:0] cmd_letter(input rfc_pkg::cmd_sel_t sel);
    logic [7:0] lc;
    case (sel)
      rfc_pkg::CMD_RED:   lc = rfc_pkg::CHR_R;
      rfc_pkg::CMD_GREEN: lc = rfc_pkg::CHR_G;
      rfc_pkg::CMD_BLUE:  lc = rfc_pkg::CHR_B;
      default:            lc = rfc_pkg::CHR_F;
    endcase
    return $urandom_range(0, 1) ? (lc & ~rfc_pkg::CASE_BIT) : lc;
  endfunction

  task automatic send_digits(input int value, input bit noisy);
    int div;
    div = 100;
    repeat (DIGITS) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_char($urandom_range(0, 1) ? rfc_pkg::CHR_A :
                  ($urandom_range(0, 1) ? rfc_pkg::CHR_D : rfc_pkg::CHR_X));
      send_char(rfc_pkg::CHR_0 + 8'((value / div) % 10));
      div = div / 10;
    end
  endtask

  task automatic run_random_traffic(input int items);
    int                sent;
    int                pick;
    int                n;
    rfc_pkg::cmd_sel_t sel;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        sel = rfc_pkg::cmd_sel_t'($urandom_range(0, 3));
        send_char(cmd_letter(sel));
        // keep most fade speeds low so levels visibly move
        send_digits((sel == rfc_pkg::CMD_FADE && $urandom_range(0, 3) != 0) ?
                    $urandom_range(0, 40) : $urandom_range(0, 999), 1'b1);
        sent += 4;
      end else if (pick < 85) begin
        send_time(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)));
        sent++;
      end else if (pick < 93) begin
        send_char(8'($urandom));
        sent++;
      end else begin
        // command broken off early
        n = $urandom_range(0, 2);
        send_char(cmd_letter(rfc_pkg::cmd_sel_t'($urandom_range(0, 3))));
        repeat (n) send_char(rfc_pkg::CHR_0 + 8'($urandom_range(0, 9)));
        send_char(8'($urandom));
        sent += n + 2;
      end
    end
  endtask

  task automatic test_time_extremes();
    send_time(16'h0000);
    send_time(16'hFFFF);
  endtask

  task automatic test_command_letters();
    send_char(rfc_pkg::CHR_R & ~rfc_pkg::CASE_BIT);
    send_digits(0, 1'b0);
    send_char(rfc_pkg::CHR_G);
    send_digits(999, 1'b0);  // wraps to 231
    send_time(16'd1);
  endtask

  task automatic test_zero_speed();
    send_char(rfc_pkg::CHR_F & ~rfc_pkg::CASE_BIT);
    send_digits(0, 1'b0);
    send_time(16'd0);
  endtask

  task automatic test_parse_errors();
    send_char(rfc_pkg::CHR_B);
    send_char(rfc_pkg::CHR_X & ~rfc_pkg::CASE_BIT);
    send_char(rfc_pkg::CHR_0 + 8'd5);
    send_char(rfc_pkg::CHR_R);  // restarts the command
    send_char("Q");             // cancels it
    send_char("#");
    send_char(8'hFF);
    send_char(rfc_pkg::CHR_A & ~rfc_pkg::CASE_BIT);
    send_char(rfc_pkg::CHR_D & ~rfc_pkg::CASE_BIT);
  endtask

  task automatic test_random_bursts();
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
    run_random_traffic(180);
  endtask

  task automatic test_output_backpressure();
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    hold_req   = 1'b1;
    run_random_traffic(40);
  endtask

  task automatic test_back_to_back();
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    run_random_traffic(120);
  endtask

  task automatic test_pattern_stall();
    gaps_on    = 1'b1;
    stall_mode = STALL_PATTERN;
    run_random_traffic(150);
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = 1'b0;
    elapsed_ms = '0;
    char_code  = '0;
    out_stall  = 1'b0;
    fader_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_time_extremes();
    test_command_letters();
    test_zero_speed();
    test_parse_errors();
    test_random_bursts();
    test_output_backpressure();
    test_back_to_back();
    test_pattern_stall();
    finish_run();
  end

  // receiver side
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    stall_phase = (stall_phase + 1) % 7;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        default:      out_stall <= (stall_phase < 3);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    led_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        $error("result transfer with no item outstanding");
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        check_field("red_level", want.red, red_level);
        check_field("green_level", want.green, green_level);
        check_field("blue_level", want.blue, blue_level);
        check_field("settled", 8'(want.settled), 8'(settled));
        check_field("status", 8'(want.status), 8'(status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
